FILE: rtl/assert_macros.svh
// assertion macros shared by the top level and parser rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define DRA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define DRA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `DRA_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// next-cycle implication
`define DRA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  `DRA_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

FILE: rtl/dra_pkg.sv
// types and constants of the dns reply a-record extractor
package dra_pkg;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_QNAME  = 4'd1,
    PH_QLABEL = 4'd2,
    PH_QPTR   = 4'd3,
    PH_QFIXED = 4'd4,
    PH_ANAME  = 4'd5,
    PH_ALABEL = 4'd6,
    PH_APTR   = 4'd7,
    PH_AFIXED = 4'd8,
    PH_RDSKIP = 4'd9,
    PH_ADDR   = 4'd10,
    PH_IDLE   = 4'd11,
    PH_NOANS  = 4'd12
  } phase_e;

  typedef enum logic [2:0] {
    ST_FOUND        = 3'd0,
    ST_SHORT        = 3'd1,
    ST_ID_MISMATCH  = 3'd2,
    ST_NOT_RESPONSE = 3'd3,
    ST_NO_ANSWERS   = 3'd4,
    ST_NO_A_RECORD  = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] address;
  } out_beat_t;

  // header byte positions
  localparam logic [3:0] HDR_ID_HI    = 4'd0;
  localparam logic [3:0] HDR_ID_LO    = 4'd1;
  localparam logic [3:0] HDR_FLAGS    = 4'd2;
  localparam logic [3:0] HDR_QD_HI    = 4'd4;
  localparam logic [3:0] HDR_QD_LO    = 4'd5;
  localparam logic [3:0] HDR_AN_HI    = 4'd6;
  localparam logic [3:0] HDR_AN_LO    = 4'd7;
  localparam logic [3:0] HDR_LAST     = 4'd11;

  // answer fixed part positions
  localparam logic [3:0] FIX_TYPE_HI  = 4'd0;
  localparam logic [3:0] FIX_TYPE_LO  = 4'd1;
  localparam logic [3:0] FIX_RDLEN_HI = 4'd8;
  localparam logic [3:0] FIX_LAST     = 4'd9;

  localparam logic [3:0]  QTAIL_LAST  = 4'd3;
  localparam logic [3:0]  ADDR_LAST   = 4'd3;
  localparam logic [7:0]  PTR_MASK    = 8'hC0;
  localparam logic [15:0] TYPE_A      = 16'd1;
  localparam logic [15:0] ADDR_LEN    = 16'd4;

endpackage

FILE: rtl/dns_reply_a_record_extractor.sv
// top level of the dns reply a-record extractor
//
// in channel: one payload byte per beat (in_valid_i/in_ready_o, in_data_i),
// last_byte set on the final byte of a reply. out channel: one beat per
// reply (out_valid_o/out_ready_i, out_data_o) with status and the ipv4
// address in wire order, address zero unless status is found.
// cfg_we_i writes cfg_wdata_i into the expected transaction id at once;
// write it only while no reply is in flight.
// a byte is captured in the input register and parsed into the result
// register: out_valid_o rises once the last byte of a reply has passed
// through both registers. throughput is one byte per cycle, set by the
// combinational parser update between them; only a last byte can wait.
// if the receiver stalls, the result register holds its beat; payload bytes
// other than the last keep flowing, while a last byte waits in the input
// register and holds input ready low until the result register frees.
// reset empties both registers, returns the parser to the header and
// clears the expected id to zero.
module dns_reply_a_record_extractor import dra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_beat_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_beat_t   out_data_o
);

  logic [15:0] expected_id_q;
  logic        in_valid_q, in_valid_d;
  in_beat_t    in_data_q;
  logic        consume;
  logic        out_free;
  logic        result_valid;
  out_beat_t   result;

  assign consume    = in_valid_q && (!in_data_q.last_byte || out_free);
  assign in_ready_o = !in_valid_q || consume;

  always_comb begin
    in_valid_d = in_valid_q;
    if (consume) in_valid_d = 1'b0;
    if (in_valid_i && in_ready_o) in_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= '0;
      in_valid_q    <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) expected_id_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  dra_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .consume_i      (consume),
    .beat_i         (in_data_q),
    .expected_id_i  (expected_id_q),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  dra_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (result_valid),
    .data_i      (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`include "assert_macros.svh"

  `DRA_ASSERT_IMP(a_mid_beat_flows, clk_i, rst_ni,
    in_valid_q && !in_data_q.last_byte, consume,
    "non-last beat stalled in input register")
  `DRA_ASSERT_IMP(a_load_when_free, clk_i, rst_ni,
    result_valid, !out_valid_o || out_ready_i,
    "result overwrote an untaken beat")
  `DRA_ASSERT_IMP(a_addr_zero_on_miss, clk_i, rst_ni,
    out_valid_o && (out_data_o.status != ST_FOUND), out_data_o.address == '0,
    "address nonzero without a hit")

endmodule

FILE: rtl/dra_parser.sv
// byte-wise parser state and result decode
module dra_parser import dra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        consume_i,
  input  in_beat_t    beat_i,
  input  logic [15:0] expected_id_i,
  output logic        result_valid_o,
  output out_beat_t   result_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  byte_index_q, byte_index_d;
  logic        id_ok_q, id_ok_d;
  logic        is_response_q, is_response_d;
  logic [15:0] questions_left_q, questions_left_d;
  logic [15:0] answers_left_q, answers_left_d;
  logic [15:0] skip_left_q, skip_left_d;
  logic [15:0] record_type_q, record_type_d;
  logic [15:0] data_length_q, data_length_d;
  logic [31:0] address_acc_q, address_acc_d;
  logic        found_q, found_d;

  logic [7:0]  b;
  logic [15:0] rdlen_full;

  assign b          = beat_i.payload_byte;
  assign rdlen_full = {data_length_q[15:8], b};

  always_comb begin
    phase_d          = phase_q;
    byte_index_d     = byte_index_q;
    id_ok_d          = id_ok_q;
    is_response_d    = is_response_q;
    questions_left_d = questions_left_q;
    answers_left_d   = answers_left_q;
    skip_left_d      = skip_left_q;
    record_type_d    = record_type_q;
    data_length_d    = data_length_q;
    address_acc_d    = address_acc_q;
    found_d          = found_q;
    case (phase_q)
      PH_HEADER: begin
        case (byte_index_q)
          HDR_ID_HI: id_ok_d = (b == expected_id_i[15:8]);
          HDR_ID_LO: id_ok_d = id_ok_q && (b == expected_id_i[7:0]);
          HDR_FLAGS: is_response_d = b[7];
          HDR_QD_HI: questions_left_d = {b, 8'h00};
          HDR_QD_LO: questions_left_d = {questions_left_q[15:8], b};
          HDR_AN_HI: answers_left_d = {b, 8'h00};
          HDR_AN_LO: answers_left_d = {answers_left_q[15:8], b};
          default: ;
        endcase
        byte_index_d = byte_index_q + 4'd1;
        if (byte_index_q == HDR_LAST) begin
          byte_index_d = '0;
          if (!id_ok_q || !is_response_q) phase_d = PH_IDLE;
          else if (answers_left_q == '0) phase_d = PH_NOANS;
          else if (questions_left_q != '0) phase_d = PH_QNAME;
          else phase_d = PH_ANAME;
        end
      end
      PH_QNAME, PH_ANAME: begin
        if (b == '0) begin
          byte_index_d = '0;
          phase_d = (phase_q == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
        end else if ((b & PTR_MASK) == PTR_MASK) begin
          phase_d = (phase_q == PH_QNAME) ? PH_QPTR : PH_APTR;
        end else begin
          skip_left_d = {8'h00, b};
          phase_d = (phase_q == PH_QNAME) ? PH_QLABEL : PH_ALABEL;
        end
      end
      PH_QLABEL, PH_ALABEL: begin
        skip_left_d = skip_left_q - 16'd1;
        if (skip_left_q == 16'd1) begin
          phase_d = (phase_q == PH_QLABEL) ? PH_QNAME : PH_ANAME;
        end
      end
      PH_QPTR: begin
        byte_index_d = '0;
        phase_d = PH_QFIXED;
      end
      PH_APTR: begin
        byte_index_d = '0;
        phase_d = PH_AFIXED;
      end
      PH_QFIXED: begin
        byte_index_d = byte_index_q + 4'd1;
        if (byte_index_q == QTAIL_LAST) begin
          byte_index_d = '0;
          questions_left_d = questions_left_q - 16'd1;
          phase_d = (questions_left_q == 16'd1) ? PH_ANAME : PH_QNAME;
        end
      end
      PH_AFIXED: begin
        case (byte_index_q)
          FIX_TYPE_HI:  record_type_d = {b, 8'h00};
          FIX_TYPE_LO:  record_type_d = {record_type_q[15:8], b};
          FIX_RDLEN_HI: data_length_d = {b, 8'h00};
          FIX_LAST:     data_length_d = rdlen_full;
          default: ;
        endcase
        byte_index_d = byte_index_q + 4'd1;
        if (byte_index_q == FIX_LAST) begin
          byte_index_d = '0;
          answers_left_d = answers_left_q - 16'd1;
          if (record_type_q == TYPE_A && rdlen_full == ADDR_LEN) begin
            address_acc_d = '0;
            phase_d = PH_ADDR;
          end else if (rdlen_full != '0) begin
            skip_left_d = rdlen_full;
            phase_d = PH_RDSKIP;
          end else begin
            phase_d = (answers_left_q == 16'd1) ? PH_IDLE : PH_ANAME;
          end
        end
      end
      PH_RDSKIP: begin
        skip_left_d = skip_left_q - 16'd1;
        if (skip_left_q == 16'd1) begin
          phase_d = (answers_left_q == '0) ? PH_IDLE : PH_ANAME;
        end
      end
      PH_ADDR: begin
        address_acc_d = {address_acc_q[23:0], b};
        byte_index_d = byte_index_q + 4'd1;
        if (byte_index_q == ADDR_LAST) begin
          byte_index_d = '0;
          found_d = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result_valid_o   = consume_i && beat_i.last_byte;
    result_o.address = '0;
    if (phase_d == PH_HEADER) result_o.status = ST_SHORT;
    else if (!id_ok_d) result_o.status = ST_ID_MISMATCH;
    else if (!is_response_d) result_o.status = ST_NOT_RESPONSE;
    else if (phase_d == PH_NOANS) result_o.status = ST_NO_ANSWERS;
    else if (found_d) begin
      result_o.status  = ST_FOUND;
      result_o.address = address_acc_d;
    end else result_o.status = ST_NO_A_RECORD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_HEADER;
      byte_index_q     <= '0;
      id_ok_q          <= 1'b1;
      is_response_q    <= 1'b0;
      questions_left_q <= '0;
      answers_left_q   <= '0;
      skip_left_q      <= '0;
      record_type_q    <= '0;
      data_length_q    <= '0;
      address_acc_q    <= '0;
      found_q          <= 1'b0;
    end else if (consume_i) begin
      if (beat_i.last_byte) begin
        phase_q          <= PH_HEADER;
        byte_index_q     <= '0;
        id_ok_q          <= 1'b1;
        is_response_q    <= 1'b0;
        questions_left_q <= '0;
        answers_left_q   <= '0;
        skip_left_q      <= '0;
        record_type_q    <= '0;
        data_length_q    <= '0;
        address_acc_q    <= '0;
        found_q          <= 1'b0;
      end else begin
        phase_q          <= phase_d;
        byte_index_q     <= byte_index_d;
        id_ok_q          <= id_ok_d;
        is_response_q    <= is_response_d;
        questions_left_q <= questions_left_d;
        answers_left_q   <= answers_left_d;
        skip_left_q      <= skip_left_d;
        record_type_q    <= record_type_d;
        data_length_q    <= data_length_d;
        address_acc_q    <= address_acc_d;
        found_q          <= found_d;
      end
    end
  end

`include "assert_macros.svh"

  `DRA_ASSERT_NXT(a_restart_after_last, clk_i, rst_ni, result_valid_o, (phase_q == PH_HEADER) && (byte_index_q == '0) && !found_q, "parser did not restart after last beat")
  `DRA_ASSERT_IMP(a_found_in_idle, clk_i, rst_ni, found_q, phase_q == PH_IDLE, "found set outside idle phase")
  `DRA_ASSERT_IMP(a_header_index, clk_i, rst_ni, phase_q == PH_HEADER, byte_index_q <= HDR_LAST, "header index out of range")

endmodule

FILE: rtl/dra_out_stage.sv
// result register toward the output channel
module dra_out_stage import dra_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_beat_t data_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  logic      valid_q, valid_d;
  out_beat_t data_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    if (out_ready_i) valid_d = 1'b0;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule
